// File: src/djs_pkg.sv
// Shared widths, job record type and sequencer states for the deadline job sequencer.
package djs_pkg;

    // Field widths of one job and one result.
    localparam int DL_W       = 10;
    localparam int PROFIT_W   = 16;
    localparam int JOB_ID_W   = 6;
    localparam int TOTAL_W    = 21;
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 32;

    // Default batch capacity.
    localparam int MAX_JOBS_DEF = 32;

    // One stored job.
    typedef struct packed {
        logic [PROFIT_W-1:0] profit;
        logic [DL_W-1:0]     deadline;
    } t_job;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        S_LOAD  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_SLOT  = 5'b00100,
        S_PUSH  = 5'b01000,
        S_FLUSH = 5'b10000
    } t_state;

endpackage

// File: src/djs_job_store.sv
// Job memory: one write port and one registered read port.
module djs_job_store
    import djs_pkg::*;
#(
    parameter int MAX_JOBS = MAX_JOBS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [$clog2(MAX_JOBS)-1:0] i_wr_addr,
    input  t_job                        i_wr_data,
    input  logic                        i_rd_en,
    input  logic [$clog2(MAX_JOBS)-1:0] i_rd_addr,
    output t_job                        o_rd_data
);

    t_job r_mem [MAX_JOBS];
    t_job r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/deadline_job_sequencer.sv
// Top level: greedy job sequencing with deadlines over a loaded batch of jobs.
//
//  Channel   Direction  tdata (low bit up)                 tlast
//  s_axis    in         deadline[9:0], profit[25:10]       last job of the batch
//  m_axis    out        job_id[5:0], total_profit[26:6]    last result of the batch
//
// Jobs load at one item per cycle while the block is in its load state.
// After the last job of a batch of n jobs the sequencer runs up to n+1
// selection rounds; each round scans all n stored jobs through the single
// memory read port, then searches slots downward one per cycle.
// Reset clears the job count, the slot and visited flags and the output stage.
// A stalled output holds the sequencer at the next result; s_axis is not
// ready until the batch's final result has been handed to the output register.
module deadline_job_sequencer
    import djs_pkg::*;
#(
    parameter int MAX_JOBS = MAX_JOBS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,   // deadline, profit
    input  logic                s_axis_tlast,   // last_job
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata,   // job_id, total_profit
    output logic                m_axis_tlast    // last_result
);

    localparam int IW = $clog2(MAX_JOBS);
    localparam int CW = $clog2(MAX_JOBS + 1);

    t_state r_state, n_state;

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_issue;
    logic                r_rd_vld;
    logic [IW-1:0]       r_rd_idx;
    logic                r_best_vld;
    logic [IW-1:0]       r_best_idx;
    logic [PROFIT_W-1:0] r_best_profit;
    logic [DL_W-1:0]     r_best_dl;
    logic [CW-1:0]       r_lim;
    logic [MAX_JOBS-1:0] r_visited;
    logic [MAX_JOBS-1:0] r_slot_taken;
    logic [TOTAL_W-1:0]  r_total;
    logic                r_pend_vld;
    logic [JOB_ID_W-1:0] r_pend_id;
    logic [TOTAL_W-1:0]  r_pend_total;
    logic                r_out_vld;
    logic [JOB_ID_W-1:0] r_out_id;
    logic [TOTAL_W-1:0]  r_out_total;
    logic                r_out_last;

    logic                w_accept;
    logic                w_store;
    logic                w_issue;
    logic                w_take;
    logic                w_scan_done;
    logic                w_out_free;
    logic [IW-1:0]       w_slot;
    logic [CW-1:0]       w_lim;
    logic [TOTAL_W-1:0]  w_sum;
    logic [JOB_ID_W-1:0] w_new_id;
    t_job                w_wr_job;
    t_job                w_rd_job;

    // Input handshake and storing of the job.
    assign s_axis_tready = (r_state == S_LOAD);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_store       = w_accept && (r_count != CW'(MAX_JOBS));
    assign w_wr_job.deadline = s_axis_tdata[DL_W-1:0];
    assign w_wr_job.profit   = s_axis_tdata[DL_W+PROFIT_W-1:DL_W];

    // Scan issue: one memory read per cycle over all stored jobs.
    assign w_issue     = (r_state == S_SCAN) && (r_issue != r_count);
    assign w_scan_done = (r_issue == r_count) && !r_rd_vld;

    djs_job_store #(
        .MAX_JOBS (MAX_JOBS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_store),
        .i_wr_addr (r_count[IW-1:0]),
        .i_wr_data (w_wr_job),
        .i_rd_en   (w_issue),
        .i_rd_addr (r_issue[IW-1:0]),
        .o_rd_data (w_rd_job)
    );

    // Best unvisited job so far: strictly higher profit wins, so ties keep the lower id.
    assign w_take = r_rd_vld && !r_visited[r_rd_idx]
                    && (!r_best_vld || (w_rd_job.profit > r_best_profit));

    // Slot limit is min(deadline, job count).
    assign w_lim  = (r_best_dl < DL_W'(r_count)) ? CW'(r_best_dl) : r_count;
    assign w_slot = IW'(r_lim - 1'b1);

    // Running total and id of the job being scheduled.
    assign w_sum    = r_total + TOTAL_W'(r_best_profit);
    assign w_new_id = JOB_ID_W'(CW'(r_best_idx) + 1'b1);

    assign w_out_free = !r_out_vld || m_axis_tready;

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (w_accept && s_axis_tlast) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (w_scan_done) n_state = r_best_vld ? S_SLOT : S_FLUSH;
            end
            S_SLOT: begin
                if (r_lim == '0) n_state = S_SCAN;
                else if (!r_slot_taken[w_slot]) n_state = S_PUSH;
            end
            S_PUSH: begin
                if (w_out_free) n_state = S_SCAN;
            end
            S_FLUSH: begin
                if (w_out_free) n_state = S_LOAD;
            end
            default: n_state = S_LOAD;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_count      <= '0;
            r_issue      <= '0;
            r_rd_vld     <= 1'b0;
            r_best_vld   <= 1'b0;
            r_visited    <= '0;
            r_slot_taken <= '0;
            r_total      <= '0;
            r_pend_vld   <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_issue;
            if (w_issue) r_issue <= r_issue + 1'b1;
            if (w_take) r_best_vld <= 1'b1;

            // Output register drains when taken.
            if (r_out_vld && m_axis_tready) r_out_vld <= 1'b0;

            case (r_state)
                S_LOAD: begin
                    if (w_store) r_count <= r_count + 1'b1;
                    if (w_accept && s_axis_tlast) begin
                        r_issue    <= '0;
                        r_best_vld <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (w_scan_done && r_best_vld) r_visited[r_best_idx] <= 1'b1;
                end
                S_SLOT: begin
                    if (r_lim == '0) begin
                        r_issue    <= '0;
                        r_best_vld <= 1'b0;
                    end else if (!r_slot_taken[w_slot]) begin
                        r_slot_taken[w_slot] <= 1'b1;
                    end
                end
                S_PUSH: begin
                    if (w_out_free) begin
                        if (r_pend_vld) r_out_vld <= 1'b1;
                        r_pend_vld <= 1'b1;
                        r_total    <= w_sum;
                        r_issue    <= '0;
                        r_best_vld <= 1'b0;
                    end
                end
                S_FLUSH: begin
                    if (w_out_free) begin
                        r_out_vld    <= 1'b1;
                        r_pend_vld   <= 1'b0;
                        r_count      <= '0;
                        r_visited    <= '0;
                        r_slot_taken <= '0;
                        r_total      <= '0;
                    end
                end
                default: begin
                    r_count <= '0;
                end
            endcase
        end
    end

    // Datapath registers: scan pipeline, best job, slot search and results.
    always_ff @(posedge i_clk) begin
        if (w_issue) r_rd_idx <= r_issue[IW-1:0];
        if (w_take) begin
            r_best_idx    <= r_rd_idx;
            r_best_profit <= w_rd_job.profit;
            r_best_dl     <= w_rd_job.deadline;
        end
        if ((r_state == S_SCAN) && w_scan_done) r_lim <= w_lim;
        if ((r_state == S_SLOT) && (r_lim != '0) && r_slot_taken[w_slot]) begin
            r_lim <= r_lim - 1'b1;
        end

        // A scheduled job waits as pending until it is known whether it is the last.
        if ((r_state == S_PUSH) && w_out_free) begin
            r_out_id     <= r_pend_id;
            r_out_total  <= r_pend_total;
            r_out_last   <= 1'b0;
            r_pend_id    <= w_new_id;
            r_pend_total <= w_sum;
        end
        if ((r_state == S_FLUSH) && w_out_free) begin
            r_out_id    <= r_pend_vld ? r_pend_id : '0;
            r_out_total <= r_pend_vld ? r_pend_total : '0;
            r_out_last  <= 1'b1;
        end
    end

    // Output channel.
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {(M_DATA_W-JOB_ID_W-TOTAL_W)'(0), r_out_total, r_out_id};

endmodule

// File: tb/tb_deadline_job_sequencer.sv
// Testbench for the deadline job sequencer: random job batches checked against a greedy schedule.
module tb_deadline_job_sequencer
    import djs_pkg::*;
();

    localparam int CAP        = MAX_JOBS_DEF;
    localparam int RAND_JOBS  = 350;
    localparam int MAX_BIG    = 6;
    localparam int LONG_HOLD  = 400;
    localparam int DRAIN      = 300;
    localparam int LIMIT      = 1000000;

    // One expected result of a batch.
    typedef struct {
        logic [JOB_ID_W-1:0] job_id;
        logic [TOTAL_W-1:0]  total;
        logic                last;
    } t_sched_entry;

    // Holds the jobs of the open batch and the schedule still to be emitted.
    class job_schedule_board;
        logic [DL_W-1:0]     dl_mem[CAP];
        logic [PROFIT_W-1:0] pr_mem[CAP];
        int                  loaded;
        t_sched_entry        sched_q[$];
        int                  fails;

        function new();
            loaded = 0;
            fails  = 0;
        endfunction

        // Appends one expected result at the tail of the schedule.
        function void queue_entry(t_sched_entry e);
            sched_q = {sched_q, e};
        endfunction

        // True if job a is visited before job b: higher profit, then lower id.
        function bit runs_first(int a, int b);
            if (pr_mem[a] != pr_mem[b]) return pr_mem[a] > pr_mem[b];
            return a < b;
        endfunction

        // Stores an accepted job; on the last job, plans the whole schedule.
        function void note_job(logic [DL_W-1:0] dl, logic [PROFIT_W-1:0] pr, logic last);
            int            order[CAP];
            bit            taken[CAP];
            int            n, k, cur, lim, nres;
            logic [TOTAL_W-1:0] total;
            t_sched_entry  e;
            if (loaded < CAP) begin
                dl_mem[loaded] = dl;
                pr_mem[loaded] = pr;
                loaded++;
            end
            if (!last) return;
            n = loaded;
            // Insertion sort into visiting order.
            for (int i = 0; i < n; i++) begin
                cur = i;
                k = i;
                while (k > 0 && runs_first(cur, order[k-1])) begin
                    order[k] = order[k-1];
                    k--;
                end
                order[k] = cur;
            end
            foreach (taken[i]) taken[i] = 1'b0;
            total = '0;
            nres = 0;
            // Each job takes the latest free slot below its limit.
            for (int i = 0; i < n; i++) begin
                lim = (dl_mem[order[i]] < n) ? int'(dl_mem[order[i]]) : n;
                while (lim > 0) begin
                    lim--;
                    if (!taken[lim]) begin
                        taken[lim] = 1'b1;
                        total = total + pr_mem[order[i]];
                        e.job_id = JOB_ID_W'(order[i] + 1);
                        e.total  = total;
                        e.last   = 1'b0;
                        queue_entry(e);
                        nres++;
                        break;
                    end
                end
            end
            if (nres == 0) begin
                e.job_id = '0;
                e.total  = '0;
                e.last   = 1'b1;
                queue_entry(e);
            end else begin
                sched_q[sched_q.size()-1].last = 1'b1;
            end
            loaded = 0;
        endfunction

        // Compares one accepted result with the oldest expectation.
        function void check_result(logic [JOB_ID_W-1:0] id, logic [TOTAL_W-1:0] total,
                                   logic last);
            t_sched_entry e;
            if (sched_q.size() == 0) begin
                fails++;
                if (fails <= 10)
                    $display("Unexpected result: id %0d total %0d last %0b", id, total, last);
                return;
            end
            e = sched_q.pop_front();
            if (id !== e.job_id || total !== e.total || last !== e.last) begin
                fails++;
                if (fails <= 10)
                    $display({"Mismatch: expected id %0d total %0d last %0b, ",
                              "got id %0d total %0d last %0b"},
                             e.job_id, e.total, e.last, id, total, last);
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata;   // deadline, profit
    logic                s_axis_tlast;   // last_job
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;   // job_id, total_profit
    logic                m_axis_tlast;   // last_result

    job_schedule_board board = new();
    int                results_seen = 0;
    int                cycles = 0;

    deadline_job_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock with a period of 10.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Timeout guard.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Output monitor: every accepted result goes to the board.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.check_result(m_axis_tdata[JOB_ID_W-1:0],
                               m_axis_tdata[JOB_ID_W +: TOTAL_W], m_axis_tlast);
            results_seen <= results_seen + 1;
        end
    end

    // Result receiver: random stalls and bursts, plus long hold-offs that back up the block.
    initial begin
        int stall, burst, r, next_hold;
        bit rdy;
        m_axis_tready = 1'b0;
        stall = 0;
        burst = 0;
        next_hold = 4;
        forever begin
            @(negedge i_clk);
            if (results_seen >= next_hold) begin
                stall = LONG_HOLD;
                next_hold = (next_hold == 4) ? 200 : 32'h7fffffff;
            end
            if (stall > 0) begin
                rdy = 1'b0;
                stall--;
            end else if (burst > 0) begin
                rdy = 1'b1;
                burst--;
            end else begin
                r = $urandom_range(0, 99);
                rdy = 1'b1;
                if (r >= 55 && r < 85) begin
                    rdy = 1'b0;
                    stall = $urandom_range(0, 3);
                end else if (r >= 85 && r < 95) begin
                    rdy = 1'b0;
                    stall = $urandom_range(5, 30);
                end else if (r >= 95) begin
                    burst = $urandom_range(30, 150);
                end
            end
            m_axis_tready <= rdy;
        end
    end

    // Idle gap before an item: mostly none or short, sometimes long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offers one job and waits for it to be accepted; starts and ends at a falling edge.
    task automatic send_job(input logic [DL_W-1:0] dl, input logic [PROFIT_W-1:0] pr,
                            input logic last, input bit no_gaps);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_DATA_W-PROFIT_W-DL_W){1'b0}}, pr, dl};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_job(dl, pr, last);
        @(negedge i_clk);
    endtask

    // Sends a batch of n random jobs in one of several flavors.
    task automatic send_batch(input int n, input bit maxed);
        bit no_gaps;
        int r;
        logic [DL_W-1:0]     dl;
        logic [PROFIT_W-1:0] pr;
        no_gaps = ($urandom_range(0, 3) == 0);
        for (int j = 0; j < n; j++) begin
            r = $urandom_range(0, 99);
            if (maxed) begin
                dl = '1;
                pr = '1;
            end else begin
                dl = (r < 75) ? DL_W'($urandom_range(0, n + 1)) : DL_W'($urandom_range(0, 1023));
                r = $urandom_range(0, 99);
                if (r < 30) pr = PROFIT_W'($urandom_range(0, 7));
                else if (r < 40) pr = PROFIT_W'(65535 - $urandom_range(0, 3));
                else pr = PROFIT_W'($urandom_range(0, 65535));
            end
            send_job(dl, pr, j == n - 1, no_gaps);
        end
    endtask

    // Main sequence: reset, directed batches, random batches, drain.
    initial begin
        int sent, n, big_left;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // A lone job with deadline zero yields the empty schedule.
        send_job(10'd0, 16'd0, 1'b1, 1'b0);
        // A lone job at the field maxima.
        send_job(10'd1023, 16'hffff, 1'b1, 1'b0);
        // Equal profits: ties go to the lower id.
        send_job(10'd2, 16'd100, 1'b0, 1'b0);
        send_job(10'd2, 16'd100, 1'b0, 1'b0);
        send_job(10'd1, 16'd100, 1'b0, 1'b0);
        send_job(10'd4, 16'd100, 1'b1, 1'b0);
        // No job can ever be scheduled.
        send_job(10'd0, 16'd500, 1'b0, 1'b1);
        send_job(10'd0, 16'hffff, 1'b0, 1'b1);
        send_job(10'd0, 16'd1, 1'b1, 1'b1);
        // Deadlines beyond the batch size and zero profits.
        send_job(10'd9, 16'd0, 1'b0, 1'b0);
        send_job(10'd700, 16'd0, 1'b0, 1'b0);
        send_job(10'd5, 16'd7, 1'b0, 1'b0);
        send_job(10'd1, 16'd0, 1'b0, 1'b0);
        send_job(10'd3, 16'd0, 1'b1, 1'b0);
        // All competing for the first slot: only the most profitable fits.
        send_job(10'd1, 16'd10, 1'b0, 1'b1);
        send_job(10'd1, 16'd40, 1'b0, 1'b1);
        send_job(10'd1, 16'd40, 1'b0, 1'b1);
        send_job(10'd1, 16'd20, 1'b1, 1'b1);
        // Alternating bit patterns.
        send_job(10'h155, 16'haaaa, 1'b1, 1'b0);
        send_job(10'h2aa, 16'h5555, 1'b1, 1'b0);

        // Overflowing batch at maximum profit: extra jobs are dropped, total nears its 21-bit top.
        send_batch(CAP + 2, 1'b1);

        sent = 0;
        big_left = MAX_BIG;
        while (sent < RAND_JOBS) begin
            if (big_left > 0 && $urandom_range(0, 99) < 6) begin
                n = $urandom_range(CAP - 4, CAP + 4);
                big_left--;
            end else begin
                n = $urandom_range(1, 8);
            end
            send_batch(n, $urandom_range(0, 19) == 0);
            sent += n;
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;

        while (board.sched_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (board.fails == 0 && board.sched_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: sim.f
src/djs_pkg.sv
src/djs_job_store.sv
src/deadline_job_sequencer.sv
tb/tb_deadline_job_sequencer.sv
